/* design/mixed_fifo_lifo_ring_queue_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the mixed FIFO/LIFO ring queue
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MIXED_FIFO_LIFO_RING_QUEUE_MACROS_SVH
`define MIXED_FIFO_LIFO_RING_QUEUE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define MFLRQ_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the result holds at the next clock edge.
`define MFLRQ_ASSERT_NEXT(name, trig, res, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) \
        else $error(msg);

`endif

/* design/mflrq_pkg.sv */
// ---------------------------------------------------------------------------
// Mixed FIFO/LIFO ring queue package
// Sizes, action codes and the step decision record shared by the queue.
// ---------------------------------------------------------------------------
package mflrq_pkg;

    localparam int RING_SLOTS = 64;
    localparam int IDX_W      = $clog2(RING_SLOTS);
    localparam int HANDLE_W   = 16;
    localparam int CNT_W      = 32;
    localparam int ACTION_W   = 2;
    localparam int OUT_BITS   = 1 + HANDLE_W + 1 + HANDLE_W + IDX_W + IDX_W + CNT_W + 1;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FIFO_PUSH = 2'd0,
        ACT_LIFO_PUSH = 2'd1,
        ACT_PULL      = 2'd2,
        ACT_NOP       = 2'd3
    } action_t;

    typedef struct packed {
        idx_t head_next;
        idx_t tail_next;
        logic wr_en;
        idx_t wr_addr;
        logic rd_en;
        idx_t rd_addr;
        logic pushed;
        logic pulled;
        logic fifo_drop;
        logic lifo_drop;
        idx_t size;
    } step_t;

endpackage

/* design/mflrq_step.sv */
// ---------------------------------------------------------------------------
// Ring queue step decoder
// Works out the slot accesses, new ring indices and size for one transfer.
// ---------------------------------------------------------------------------
module mflrq_step (
    input  mflrq_pkg::action_t action,
    input  mflrq_pkg::idx_t    head,
    input  mflrq_pkg::idx_t    tail,
    input  mflrq_pkg::idx_t    last,
    output mflrq_pkg::step_t   step
);
    import mflrq_pkg::*;

    idx_t             tail_inc;
    idx_t             head_dec;
    idx_t             tail_dec;
    idx_t             h_n;
    idx_t             t_n;
    logic [IDX_W:0]   wrap_size;

    assign tail_inc = (tail == last) ? '0 : tail + idx_t'(1);
    assign head_dec = (head == '0) ? last : head - idx_t'(1);
    assign tail_dec = (tail == '0) ? last : tail - idx_t'(1);

    always_comb
    begin
        h_n            = head;
        t_n            = tail;
        step.wr_en     = 1'b0;
        step.wr_addr   = tail;
        step.rd_en     = 1'b0;
        step.rd_addr   = head;
        step.pushed    = 1'b0;
        step.pulled    = 1'b0;
        step.fifo_drop = 1'b0;
        step.lifo_drop = 1'b0;
        unique case (action)
            ACT_FIFO_PUSH:
            begin
                step.pushed = 1'b1;
                if (tail_inc == head)
                begin
                    step.fifo_drop = 1'b1;
                end
                else
                begin
                    step.wr_en = 1'b1;
                    t_n        = tail_inc;
                end
            end
            ACT_LIFO_PUSH:
            begin
                step.pushed  = 1'b1;
                step.wr_en   = 1'b1;
                step.wr_addr = head_dec;
                h_n          = head_dec;
                if (head_dec == tail)
                begin
                    step.lifo_drop = 1'b1;
                    step.rd_en     = 1'b1;
                    step.rd_addr   = tail_dec;
                    t_n            = tail_dec;
                end
            end
            ACT_PULL:
            begin
                if (head != tail)
                begin
                    step.pulled = 1'b1;
                    step.rd_en  = 1'b1;
                    h_n         = (head == last) ? '0 : head + idx_t'(1);
                end
            end
            default:
            begin
            end
        endcase
        step.head_next = h_n;
        step.tail_next = t_n;
        if (t_n >= h_n)
        begin
            wrap_size = {1'b0, t_n} - {1'b0, h_n};
        end
        else
        begin
            wrap_size = {1'b0, t_n} + {1'b0, last} + (IDX_W + 1)'(1) - {1'b0, h_n};
        end
        step.size = wrap_size[IDX_W-1:0];
    end

endmodule

/* design/mixed_fifo_lifo_ring_queue.sv */
// ---------------------------------------------------------------------------
// Mixed FIFO/LIFO ring queue
// Double-ended ring buffer of packet handles with FIFO push, LIFO push and
// pull, drop counting, high-water tracking and a wake notice.
// ---------------------------------------------------------------------------
// An accepted transfer waits in the pending register, then moves to the output.
// Throughput: one transfer per cycle, set by the single read port of the slot
// memory, which is read on the accepting edge into a read data register that
// feeds the output register; a stalled output register holds off new input.
// Reset clears the ring indices, drop count and high-water mark and sets the
// capacity to 63; slot contents are not cleared, so no clearing pass is needed.
`include "mixed_fifo_lifo_ring_queue_macros.svh"

module mixed_fifo_lifo_ring_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // Fields from bit 0: packet_handle.
    input  logic [mflrq_pkg::HANDLE_W-1:0] s_tdata,
    // Fields from bit 0: action.
    input  logic [mflrq_pkg::ACTION_W-1:0] s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // Fields from bit 0: out_valid, out_handle, drop_valid, dropped_handle,
    // queue_size, highwater_size, drop_total, became_nonempty, zero pad.
    output logic [mflrq_pkg::OUT_W-1:0]  m_tdata,
    input  logic                         cfg_we,
    input  logic [mflrq_pkg::IDX_W-1:0]  cfg_wdata
);
    import mflrq_pkg::*;

    typedef struct packed {
        logic    out_valid;
        logic    drop_valid;
        logic    drop_from_mem;
        handle_t handle;
        idx_t    size;
        idx_t    highwater;
        cnt_t    drop_total;
        logic    woke;
    } pend_t;

    handle_t slot_mem [RING_SLOTS];
    handle_t rd_data_reg;

    idx_t    head_reg;
    idx_t    tail_reg;
    idx_t    last_reg;
    cnt_t    drop_cnt_reg;
    cnt_t    drop_cnt_next;
    idx_t    hw_reg;
    idx_t    hw_next;
    logic    pend_reg;
    pend_t   pend_data_reg;
    logic    m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    step_t   step;
    logic    accept;
    logic    out_load;
    handle_t out_handle;
    handle_t dropped_handle;

    mflrq_step u_step (
        .action (action_t'(s_tuser)),
        .head   (head_reg),
        .tail   (tail_reg),
        .last   (last_reg),
        .step   (step)
    );

    assign out_load = pend_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !pend_reg || out_load;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        drop_cnt_next = drop_cnt_reg;
        if ((step.fifo_drop || step.lifo_drop) && (drop_cnt_reg != '1))
        begin
            drop_cnt_next = drop_cnt_reg + cnt_t'(1);
        end
        hw_next = hw_reg;
        if (step.pushed && (step.size > hw_reg))
        begin
            hw_next = step.size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step.wr_en)
        begin
            slot_mem[step.wr_addr] <= s_tdata;
        end
        if (accept && step.rd_en)
        begin
            rd_data_reg <= slot_mem[step.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            last_reg     <= idx_t'(RING_SLOTS - 1);
            drop_cnt_reg <= '0;
            hw_reg       <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                last_reg <= (cfg_wdata == '0) ? idx_t'(1) : cfg_wdata;
                head_reg <= '0;
                tail_reg <= '0;
            end
            else if (accept)
            begin
                head_reg <= step.head_next;
                tail_reg <= step.tail_next;
            end
            if (accept)
            begin
                drop_cnt_reg <= drop_cnt_next;
                hw_reg       <= hw_next;
                pend_reg     <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_data_reg.out_valid     <= step.pulled;
            pend_data_reg.drop_valid    <= step.fifo_drop || step.lifo_drop;
            pend_data_reg.drop_from_mem <= step.lifo_drop;
            pend_data_reg.handle        <= s_tdata;
            pend_data_reg.size          <= step.size;
            pend_data_reg.highwater     <= hw_next;
            pend_data_reg.drop_total    <= drop_cnt_next;
            pend_data_reg.woke          <= step.pushed && (step.size == idx_t'(1));
        end
    end

    assign out_handle     = pend_data_reg.out_valid ? rd_data_reg : '0;
    assign dropped_handle = !pend_data_reg.drop_valid   ? '0 :
                            pend_data_reg.drop_from_mem ? rd_data_reg :
                                                          pend_data_reg.handle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {{(OUT_W - OUT_BITS){1'b0}},
                            pend_data_reg.woke,
                            pend_data_reg.drop_total,
                            pend_data_reg.highwater,
                            pend_data_reg.size,
                            dropped_handle,
                            pend_data_reg.drop_valid,
                            out_handle,
                            pend_data_reg.out_valid};
        end
    end

    `MFLRQ_ASSERT_ALWAYS(a_idx_in_ring, (head_reg <= last_reg) && (tail_reg <= last_reg),
        "ring index beyond the configured ring length")
    `MFLRQ_ASSERT_NEXT(a_accept_pends, accept, pend_reg,
        "accepted transfer did not reach the pending stage")
    `MFLRQ_ASSERT_NEXT(a_stall_holds, pend_reg && !out_load, pend_reg,
        "pending result lost while the output register was stalled")
    `MFLRQ_ASSERT_NEXT(a_drop_count_monotonic, 1'b1, drop_cnt_reg >= $past(drop_cnt_reg),
        "drop counter decreased")

endmodule
